>>> design/wspm_pkg.sv
package wspm_pkg;

  localparam int MAX_PATTERN  = 8;
  localparam int LINE_WIDTH   = 20;
  localparam int COLUMN_WIDTH = 16;
  localparam int LEN_WIDTH    = 4;
  localparam int BYTES_WIDTH  = 64;
  localparam int IDX_WIDTH    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CFG_INDEX_WIDTH = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_BYTES  = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_LENGTH = 1'd1;

  // Whitespace characters.
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [LINE_WIDTH-1:0]   match_line;
    logic [COLUMN_WIDTH-1:0] match_column;
  } out_item_t;

  typedef struct packed {
    logic                       we;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [BYTES_WIDTH-1:0]     data;
  } cfg_write_t;

  typedef struct packed {
    logic      hit;
    out_item_t item;
  } match_result_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_NEWLINE);
  endfunction

endpackage

>>> design/wspm_match.sv
module wspm_match (
  input  logic                   clk,
  input  logic                   rst,
  input  wspm_pkg::cfg_write_t   cfg,
  input  logic                   fire,
  input  wspm_pkg::in_item_t     item,
  output wspm_pkg::match_result_t result
);
  import wspm_pkg::*;

  localparam logic [LINE_WIDTH-1:0]   LINE_MAX = {LINE_WIDTH{1'b1}};
  localparam logic [COLUMN_WIDTH-1:0] COL_MAX  = {COLUMN_WIDTH{1'b1}};

  logic [BYTES_WIDTH-1:0]  pattern_bytes;
  logic [LEN_WIDTH-1:0]    pattern_length;
  logic [MAX_PATTERN-1:0]  mask;
  logic [LINE_WIDTH-1:0]   current_line;
  logic [COLUMN_WIDTH-1:0] current_column;
  logic [LINE_WIDTH-1:0]   start_line   [MAX_PATTERN];
  logic [COLUMN_WIDTH-1:0] start_column [MAX_PATTERN];

  logic [IDX_WIDTH-1:0]    last;
  logic [MAX_PATTERN-1:0]  keep;
  logic [LINE_WIDTH-1:0]   line_base, line_next;
  logic [COLUMN_WIDTH-1:0] column_base, column_next;
  logic [MAX_PATTERN-1:0]  mask_base, mask_next;
  logic                    blank;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= LEN_WIDTH'(1);
    end else if (cfg.we) begin
      case (cfg.index)
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg.data;
        REG_PATTERN_LENGTH: pattern_length <= cfg.data[LEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // A length of zero behaves as one, anything above the maximum as the maximum.
  always_comb begin
    if (pattern_length == '0) begin
      last = '0;
    end else if (pattern_length > LEN_WIDTH'(MAX_PATTERN)) begin
      last = IDX_WIDTH'(MAX_PATTERN - 1);
    end else begin
      last = IDX_WIDTH'(pattern_length - LEN_WIDTH'(1));
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      keep[i] = (IDX_WIDTH'(i) <= last);
    end
  end

  always_comb begin
    line_base   = item.file_start ? LINE_WIDTH'(1) : current_line;
    column_base = item.file_start ? '0 : current_column;
    mask_base   = (item.file_start ? '0 : mask) & keep;
    if (item.text_byte == CHAR_NEWLINE) begin
      line_next   = (line_base == LINE_MAX) ? line_base : line_base + LINE_WIDTH'(1);
      column_next = '0;
    end else begin
      line_next   = line_base;
      column_next = (column_base == COL_MAX) ? column_base
                                             : column_base + COLUMN_WIDTH'(1);
    end
    blank = is_blank(item.text_byte);
    mask_next[0] = keep[0] && (pattern_bytes[7:0] == item.text_byte);
    for (int i = 1; i < MAX_PATTERN; i++) begin
      mask_next[i] = keep[i] && mask_base[i-1]
                     && (pattern_bytes[8*i +: 8] == item.text_byte);
    end
  end

  always_comb begin
    result.hit = !blank && mask_next[last];
    if (last == '0) begin
      result.item.match_line   = line_next;
      result.item.match_column = column_next;
    end else begin
      result.item.match_line   = start_line[last - IDX_WIDTH'(1)];
      result.item.match_column = start_column[last - IDX_WIDTH'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask           <= '0;
      current_line   <= LINE_WIDTH'(1);
      current_column <= '0;
    end else if (fire) begin
      current_line   <= line_next;
      current_column <= column_next;
      mask           <= blank ? mask_base : mask_next;
    end
  end

  // Start positions shift along with the partial-match bits.
  always_ff @(posedge clk) begin
    if (fire && !blank) begin
      start_line[0]   <= line_next;
      start_column[0] <= column_next;
      for (int i = 1; i < MAX_PATTERN; i++) begin
        start_line[i]   <= start_line[i-1];
        start_column[i] <= start_column[i-1];
      end
    end
  end

`ifndef SYNTHESIS
  a_hit_leaves_last_bit: assert property (@(posedge clk) disable iff (rst)
    (fire && result.hit) |=> mask[$past(last)])
    else $error("reported match not left in partial-match vector");

  a_file_start_newline: assert property (@(posedge clk) disable iff (rst)
    (fire && item.file_start && item.text_byte == CHAR_NEWLINE)
      |=> (current_line == LINE_WIDTH'(2) && current_column == '0))
    else $error("newline at file start did not move to line two");

  a_blank_keeps_starts: assert property (@(posedge clk) disable iff (rst)
    (fire && blank) |=> (mask == ($past(mask_base))))
    else $error("whitespace byte changed partial matches");
`endif

endmodule

>>> design/whitespace_skipping_pattern_matcher_unit.sv
// Whitespace-skipping pattern matcher. Text bytes come in on the text channel
// and every occurrence of the configured pattern (one to eight non-blank
// characters, overlapping occurrences included) yields one request on the
// match channel carrying the 1-based line and column of the first matched
// character; spaces, tabs and newlines between pattern characters are skipped.
// The unit takes one byte every clock cycle for as long as the match channel
// keeps up: the byte is held in the input register, the shift-and update of
// the partial-match vector and line/column counters runs while it sits there,
// and a match is registered from there into the output register. Behind the
// output register is one skid entry, so text is stalled only while that
// entry holds a match that the match channel has not yet taken.
// Configuration writes are meant for idle periods.
module whitespace_skipping_pattern_matcher_unit (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    text_valid,
  output logic                                    text_stall,
  input  wspm_pkg::in_item_t                      text_item,
  output logic                                    match_valid,
  input  logic                                    match_stall,
  output wspm_pkg::out_item_t                     match_item,
  input  logic                                    cfg_we,
  input  logic [wspm_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [wspm_pkg::BYTES_WIDTH-1:0]        cfg_data
);
  import wspm_pkg::*;

  // Input register: one accepted text byte waiting to be processed.
  logic          s1_valid;
  in_item_t      s1_item;

  // Skid entry behind the output register.
  logic          skid_valid;
  out_item_t     skid_item;

  logic          accept;
  logic          fire;
  logic          out_free;
  cfg_write_t    cfg;
  match_result_t result;

  // The input register drains whenever the skid entry is empty, since a
  // match it produces then always has somewhere to go.
  assign text_stall = skid_valid;
  assign accept     = text_valid && !text_stall;
  assign fire       = s1_valid && !skid_valid;
  assign out_free   = !match_valid || !match_stall;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  wspm_match u_match (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (s1_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= text_item;
    end
  end

  // Output register and skid entry. A stalled output register that gets a
  // fresh match parks it in the skid entry; the skid entry moves up first
  // whenever the output register frees.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        match_valid <= 1'b1;
        skid_valid  <= 1'b0;
      end else begin
        match_valid <= fire && result.hit;
      end
    end else if (fire && result.hit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        match_item <= skid_item;
      end else if (fire && result.hit) begin
        match_item <= result.item;
      end
    end else if (fire && result.hit) begin
      skid_item <= result.item;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> match_valid)
    else $error("skid entry full while output register is empty");

  a_stalled_hit_parks: assert property (@(posedge clk) disable iff (rst)
    (match_valid && match_stall && fire && result.hit) |=> (skid_valid && match_valid))
    else $error("match produced under stall was not parked");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !match_stall) |=> (!skid_valid && match_valid))
    else $error("skid entry did not move into the output register");

  a_no_fire_with_skid: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !fire)
    else $error("byte processed while skid entry is full");
`endif

endmodule

>>> bench/tb_whitespace_skipping_pattern_matcher_unit.sv
`timescale 1ns / 100ps

module tb_whitespace_skipping_pattern_matcher_unit;
  import wspm_pkg::*;

  // Cycles to let pass after the last predicted match before the block is taken
  // as idle. A byte passes the input register before it reaches the output
  // register, so the drain also covers a byte that produced no match.
  localparam int DRAIN_CYCLES = 4;
  // Receiver hold-off used to fill the output register and skid entry.
  localparam int HOLD_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT = 100_000;
  // Random bytes to send after the directed part.
  localparam int unsigned RANDOM_ITEMS = 1830;
  localparam int NUM_ROWS = 32;

  typedef enum logic {
    ROW_WRITE,
    ROW_TEXT
  } row_kind_e;

  // One line of the directed script. For text rows, flag is the file_start bit
  // of the first byte of the run. For write rows, flag is the register index.
  // A typed row carries the match that the last byte of the run must produce.
  typedef struct packed {
    row_kind_e              kind;
    logic [BYTES_WIDTH-1:0] value;
    logic                   flag;
    logic [20:0]            repeats;
    logic                   typed;
    out_item_t              want;
  } script_row_t;

  logic clk;
  logic rst;
  logic text_valid;
  logic text_stall;
  in_item_t text_item;
  logic match_valid;
  logic match_stall;
  out_item_t match_item;
  logic cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [BYTES_WIDTH-1:0] cfg_data;

  // Set by the stimulus when the receiver should stop taking matches for a
  // long while.
  logic hold_request;
  // While set, neither side inserts idle cycles.
  logic calm;

  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  // Matches predicted for accepted bytes, oldest first.
  out_item_t predicted_matches[$];
  out_item_t oldest_match;

  // Shadow of the matcher: configuration and the state it keeps per stream.
  logic [BYTES_WIDTH-1:0]  shadow_pattern = '0;
  logic [LEN_WIDTH-1:0]    shadow_length = 4'd1;
  logic [MAX_PATTERN-1:0]  shadow_partials = '0;
  logic [LINE_WIDTH-1:0]   shadow_start_line [MAX_PATTERN];
  logic [COLUMN_WIDTH-1:0] shadow_start_column [MAX_PATTERN];
  logic [LINE_WIDTH-1:0]   shadow_line = 1;
  logic [COLUMN_WIDTH-1:0] shadow_column = 0;

  script_row_t script [NUM_ROWS];

  whitespace_skipping_pattern_matcher_unit dut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_item   (text_item),
    .match_valid (match_valid),
    .match_stall (match_stall),
    .match_item  (match_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Shift-and step of the matcher for one accepted byte. It updates the shadow
  // state and returns the match that the byte completes, if any.
  function automatic match_result_t advance_matcher(input in_item_t req);
    int len;
    logic [MAX_PATTERN-1:0] keep;
    logic [MAX_PATTERN-1:0] next_partials;
    logic [7:0] b;
    match_result_t res;
    res = '0;
    b = req.text_byte;
    // Out-of-range lengths are clamped to the range the matcher supports.
    if (shadow_length == 0) len = 1;
    else if (shadow_length > MAX_PATTERN) len = MAX_PATTERN;
    else len = shadow_length;
    keep = {MAX_PATTERN{1'b1}} >> (MAX_PATTERN - len);
    next_partials = '0;
    if (req.file_start) begin
      shadow_partials = '0;
      shadow_line = 1;
      shadow_column = 0;
    end
    // The byte's own position is the one after this update; both counters
    // stick at their maximum.
    if (b == CHAR_NEWLINE) begin
      if (shadow_line != {LINE_WIDTH{1'b1}}) shadow_line++;
      shadow_column = 0;
    end else if (shadow_column != {COLUMN_WIDTH{1'b1}}) begin
      shadow_column++;
    end
    // A shorter length written since the last byte drops the partial matches
    // that no longer fit.
    shadow_partials &= keep;
    // Blanks neither start nor extend a match, and they leave the partial
    // matches as they are. A blank pattern character thus never matches.
    if (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_NEWLINE) return res;
    for (int i = len - 1; i > 0; i--) begin
      shadow_start_line[i] = shadow_start_line[i-1];
      shadow_start_column[i] = shadow_start_column[i-1];
      if (shadow_partials[i-1] && shadow_pattern[8*i +: 8] == b) next_partials[i] = 1'b1;
    end
    shadow_start_line[0] = shadow_line;
    shadow_start_column[0] = shadow_column;
    if (shadow_pattern[7:0] == b) next_partials[0] = 1'b1;
    shadow_partials = next_partials & keep;
    if (shadow_partials[len-1]) begin
      res.hit = 1'b1;
      res.item.match_line = shadow_start_line[len-1];
      res.item.match_column = shadow_start_column[len-1];
    end
    return res;
  endfunction

  // Offers one text request and returns at the falling edge after it has been
  // taken. Valid stays high from one request to the next unless an idle cycle
  // is drawn, so back-to-back requests run at one byte per cycle while the block does not stall its input.
  task automatic send_text(input in_item_t req, input logic typed, input out_item_t typed_match);
    match_result_t res;
    while (!calm && $urandom_range(99) < 29) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text_item <= req;
    do @(posedge clk); while (text_stall);
    items_sent++;
    res = advance_matcher(req);
    // A typed row stands for itself: its match is queued whatever the shadow
    // says, so a slip in the shadow shows up against the block.
    if (typed) predicted_matches.push_back(typed_match);
    else if (res.hit) predicted_matches.push_back(res.item);
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted match has come out, then
  // lets the pipeline empty of bytes that produce no match.
  task automatic settle();
    text_valid <= 1'b0;
    while (predicted_matches.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                           input logic [BYTES_WIDTH-1:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    case (index)
      REG_PATTERN_BYTES: shadow_pattern = data;
      REG_PATTERN_LENGTH: shadow_length = data[LEN_WIDTH-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] any_blank();
    case ($urandom_range(2))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      default: return CHAR_NEWLINE;
    endcase
  endfunction

  // Random text bytes open a new file now and then.
  function automatic in_item_t text_of(input logic [7:0] b);
    in_item_t req;
    req.text_byte = b;
    req.file_start = ($urandom_range(99) < 2);
    return req;
  endfunction

  // Bytes drawn mostly from a four-letter alphabet so that patterns and text
  // meet often; the rest are blanks or any byte at all.
  function automatic logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(3));
  endfunction

  // Receiver: stalls at random, except in calm stretches and during the one
  // long hold-off that fills the block up.
  initial begin
    logic hold_taken;
    hold_taken = 1'b0;
    match_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        match_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        match_stall <= !calm && ($urandom_range(99) < 29);
      end
    end
  end

  // Every match taken is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && match_valid && !match_stall) begin
      if (predicted_matches.size() == 0) begin
        $error("match with none predicted: line %0d column %0d",
               match_item.match_line, match_item.match_column);
        mismatch_count++;
      end else begin
        oldest_match = predicted_matches.pop_front();
        if (match_item.match_line !== oldest_match.match_line) begin
          $error("match_line: expected %0d, got %0d",
                 oldest_match.match_line, match_item.match_line);
          mismatch_count++;
        end
        if (match_item.match_column !== oldest_match.match_column) begin
          $error("match_column: expected %0d, got %0d",
                 oldest_match.match_column, match_item.match_column);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    in_item_t req;
    logic [BYTES_WIDTH-1:0] pattern;
    logic [LEN_WIDTH-1:0] len_code;
    int pattern_len;
    int unsigned random_goal;
    int unsigned phase_goal;
    int unsigned budget;
    int phase;
    int pick;
    logic paused;

    rst = 1'b1;
    text_valid = 1'b0;
    text_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_request = 1'b0;
    calm = 1'b0;

    // Directed script. Byte values: 0x61..0x64 are a..d.
    script = '{
      // Straight after reset the pattern is a single NUL byte.
      '{ROW_TEXT,  64'h00, 1'b0, 21'd1, 1'b1, '{20'd1, 16'd1}},
      // "abc" with a space, a tab and a newline between its characters.
      '{ROW_WRITE, 64'h63_6261, REG_PATTERN_BYTES, 21'd1, 1'b0, '0},
      '{ROW_WRITE, 64'd3, REG_PATTERN_LENGTH, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h61, 1'b1, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h20, 1'b0, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h62, 1'b0, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h09, 1'b0, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h0A, 1'b0, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h63, 1'b0, 21'd1, 1'b0, '0},
      // A new file in the middle of a match throws the partial match away.
      '{ROW_TEXT,  64'h61, 1'b1, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h62, 1'b0, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h61, 1'b1, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h62, 1'b0, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h63, 1'b0, 21'd1, 1'b0, '0},
      // All-ones pattern with a length above the maximum, then a length of
      // zero; overlapping runs of 0xFF.
      '{ROW_WRITE, {BYTES_WIDTH{1'b1}}, REG_PATTERN_BYTES, 21'd1, 1'b0, '0},
      '{ROW_WRITE, 64'd15, REG_PATTERN_LENGTH, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'hFF, 1'b1, 21'd9, 1'b0, '0},
      '{ROW_WRITE, 64'd0, REG_PATTERN_LENGTH, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'hFF, 1'b0, 21'd2, 1'b0, '0},
      // A pattern that starts with a space can never match.
      '{ROW_WRITE, 64'h6120, REG_PATTERN_BYTES, 21'd1, 1'b0, '0},
      '{ROW_WRITE, 64'd2, REG_PATTERN_LENGTH, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h20, 1'b0, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h61, 1'b0, 21'd2, 1'b0, '0},
      // The length shrinks while "abc" of "abcd" is pending.
      '{ROW_WRITE, 64'h6463_6261, REG_PATTERN_BYTES, 21'd1, 1'b0, '0},
      '{ROW_WRITE, 64'd4, REG_PATTERN_LENGTH, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h61, 1'b1, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h62, 1'b0, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h63, 1'b0, 21'd1, 1'b0, '0},
      '{ROW_WRITE, 64'd2, REG_PATTERN_LENGTH, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h64, 1'b0, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h61, 1'b0, 21'd1, 1'b0, '0},
      '{ROW_TEXT,  64'h62, 1'b0, 21'd1, 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[r]) begin
      if (script[r].kind == ROW_WRITE) begin
        write_reg(script[r].flag, script[r].value);
      end else begin
        for (int n = 0; n < script[r].repeats; n++) begin
          req.text_byte = script[r].value[7:0];
          req.file_start = script[r].flag && (n == 0);
          send_text(req, script[r].typed && (n == script[r].repeats - 1), script[r].want);
        end
      end
    end

    // Back pressure: every "q" matches, the receiver holds off for a long
    // while, and the sender keeps offering until the block stalls its input.
    write_reg(REG_PATTERN_BYTES, 64'h71);
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    hold_request = 1'b1;
    for (int n = 0; n < 40; n++) begin
      req.text_byte = 8'h71;
      req.file_start = (n == 0);
      send_text(req, 1'b0, '0);
    end

    // Random phases. Each writes a new pattern and length (every fourth only
    // a length, with partial matches still pending), then sends mostly
    // occurrences of the pattern with blanks mixed in, plus noise.
    random_goal = items_sent + RANDOM_ITEMS;
    phase = 0;
    pattern = '0;
    pattern_len = 1;
    while (items_sent < random_goal) begin
      calm = (phase == 2);
      if (phase % 4 != 3) begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
          pick = $urandom_range(99);
          if (pick < 80) pattern[8*k +: 8] = letter();
          else if (pick < 93) pattern[8*k +: 8] = 8'($urandom_range(255));
          else pattern[8*k +: 8] = any_blank();
        end
        write_reg(REG_PATTERN_BYTES, pattern);
      end
      case ($urandom_range(9))
        0: len_code = 4'd0;
        1: len_code = 4'd15;
        2: len_code = 4'd8;
        3: len_code = 4'd1;
        default: len_code = 4'($urandom_range(15));
      endcase
      write_reg(REG_PATTERN_LENGTH, {{(BYTES_WIDTH-LEN_WIDTH){1'b0}}, len_code});
      if (len_code == 0) pattern_len = 1;
      else if (len_code > MAX_PATTERN) pattern_len = MAX_PATTERN;
      else pattern_len = len_code;

      budget = $urandom_range(200, 100);
      phase_goal = items_sent + budget;
      paused = 1'b0;
      while (items_sent < phase_goal) begin
        // Once, the sender stops until all matches so far have come out.
        if (phase == 1 && !paused && items_sent > phase_goal - budget / 2) begin
          settle();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 55) begin
          for (int k = 0; k < pattern_len; k++) begin
            send_text(text_of(pattern[8*k +: 8]), 1'b0, '0);
            if ($urandom_range(99) < 25) send_text(text_of(any_blank()), 1'b0, '0);
          end
        end else begin
          pick = $urandom_range(99);
          if (pick < 65) send_text(text_of(letter()), 1'b0, '0);
          else if (pick < 80) send_text(text_of(any_blank()), 1'b0, '0);
          else send_text(text_of(8'($urandom_range(255))), 1'b0, '0);
        end
      end
      calm = 1'b0;
      phase++;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/wspm_pkg.sv
design/wspm_match.sv
design/whitespace_skipping_pattern_matcher_unit.sv
bench/tb_whitespace_skipping_pattern_matcher_unit.sv
